>>> sv/bmmd_pkg.sv
// Shared types, codes and reset table of the banked memory map decoder
`timescale 1ns / 1ps
package bmmd_pkg;

   localparam int SPRITE_BYTES_DEF = 160;
   localparam int WORK_BANKS_DEF   = 8;
   localparam int VIDEO_DEPTH      = 16384;
   localparam int BANK_BYTES       = 4096;
   localparam int HIGH_DEPTH       = 127;
   localparam int IO_DEPTH         = 128;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_DMA   = 2'd2;

   localparam logic [2:0] TGT_INT   = 3'd0;
   localparam logic [2:0] TGT_ROM   = 3'd1;
   localparam logic [2:0] TGT_CRAM  = 3'd2;
   localparam logic [2:0] TGT_SOUND = 3'd3;
   localparam logic [2:0] TGT_JOY   = 3'd4;
   localparam logic [2:0] TGT_PAL   = 3'd5;
   localparam logic [2:0] TGT_NONE  = 3'd6;

   localparam logic [6:0] IO_JOY  = 7'h00;
   localparam logic [6:0] IO_DIV  = 7'h04;
   localparam logic [6:0] IO_DMA  = 7'h46;
   localparam logic [6:0] IO_VBK  = 7'h4F;
   localparam logic [6:0] IO_SVBK = 7'h70;

   typedef enum logic [3:0] {
      RGN_ROM,
      RGN_VIDEO,
      RGN_CRAM,
      RGN_WORK,
      RGN_SPRITE,
      RGN_NONE,
      RGN_IO,
      RGN_HIGH,
      RGN_IE
   } region_type;

   typedef struct packed {
      region_type  region;
      logic [2:0]  target;
      logic [13:0] video_addr;
      logic [14:0] work_addr;
      logic [7:0]  sprite_addr;
      logic [6:0]  low_addr;
   } dec_type;

   function automatic logic is_sound(input logic [6:0] r);
      return (r >= 7'h10 && r <= 7'h26) || (r >= 7'h30 && r <= 7'h3F);
   endfunction

   function automatic logic is_palette(input logic [6:0] r);
      return r >= 7'h68 && r <= 7'h6B;
   endfunction

   function automatic logic [7:0] boot_io(input logic [6:0] r);
      logic [7:0] v;
      case (r)
         7'h00: v = 8'hCF;
         7'h02: v = 8'h7E;
         7'h04: v = 8'hAB;
         7'h07: v = 8'hF8;
         7'h0F: v = 8'hE1;
         7'h10: v = 8'h80;
         7'h11: v = 8'hBF;
         7'h12: v = 8'hF3;
         7'h13: v = 8'hFF;
         7'h14: v = 8'hBF;
         7'h16: v = 8'h3F;
         7'h18: v = 8'hFF;
         7'h19: v = 8'hBF;
         7'h1A: v = 8'h7F;
         7'h1B: v = 8'hFF;
         7'h1C: v = 8'h9F;
         7'h1D: v = 8'hFF;
         7'h1E: v = 8'hBF;
         7'h20: v = 8'hFF;
         7'h23: v = 8'hBF;
         7'h24: v = 8'h77;
         7'h25: v = 8'hF3;
         7'h26: v = 8'hF1;
         7'h40: v = 8'h91;
         7'h41: v = 8'h85;
         7'h47: v = 8'hFC;
         7'h48: v = 8'hFF;
         7'h49: v = 8'hFF;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

>>> sv/bmmd_if.sv
// Valid/ready channel interfaces for request, response and control words
`timescale 1ns / 1ps
interface bmmd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [7:0]  external_data;
   modport source (output valid, mode, address, write_data, external_data, input ready);
   modport sink (input valid, mode, address, write_data, external_data, output ready);
endinterface

interface bmmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [2:0]  target;
   logic [15:0] external_address;
   logic        external_write;
   logic        dma_busy;
   modport source (output valid, read_data, target, external_address, external_write,
                   dma_busy, input ready);
   modport sink (input valid, read_data, target, external_address, external_write,
                 dma_busy, output ready);
endinterface

interface bmmd_csr_if;
   logic valid;
   logic ready;
   logic colour_mode;
   modport source (output valid, colour_mode, input ready);
   modport sink (input valid, colour_mode, output ready);
endinterface

>>> sv/bmmd_ram.sv
// Generic single-port synchronous RAM with registered read
`timescale 1ns / 1ps
module bmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/bmmd_decode.sv
// Address decoder: region, target and per-store index for one bus address
`timescale 1ns / 1ps
module bmmd_decode #(
   parameter int SPRITE_BYTES = bmmd_pkg::SPRITE_BYTES_DEF,
   parameter int WORK_BANKS   = bmmd_pkg::WORK_BANKS_DEF
) (
   input  logic [15:0]       address,
   input  logic              colour_mode,
   input  logic              video_bank,
   input  logic [2:0]        work_bank,
   output bmmd_pkg::dec_type dec
);
   import bmmd_pkg::*;

   logic [15:0] wa;
   logic [2:0]  bank;
   logic [2:0]  bank_sat;
   logic [6:0]  r;
   logic        sprite_hit;

   always_comb begin
      wa = (address >= 16'hE000) ? address - 16'h2000 : address;
      if (wa[15:12] == 4'hC) begin
         bank = 3'd0;
      end else if (colour_mode) begin
         bank = work_bank;
      end else begin
         bank = 3'd1;
      end
      bank_sat = ({1'b0, bank} >= 4'(WORK_BANKS)) ? 3'(WORK_BANKS - 1) : bank;
      r = address[6:0];
      sprite_hit = {1'b0, address} < (17'h0FE00 + 17'(SPRITE_BYTES));

      dec.video_addr  = {colour_mode & video_bank, address[12:0]};
      dec.work_addr   = {bank_sat, wa[11:0]};
      dec.sprite_addr = address[7:0];
      dec.low_addr    = r;
      dec.target      = TGT_INT;

      if (address < 16'h8000) begin
         dec.region = RGN_ROM;
         dec.target = TGT_ROM;
      end else if (address < 16'hA000) begin
         dec.region = RGN_VIDEO;
      end else if (address < 16'hC000) begin
         dec.region = RGN_CRAM;
         dec.target = TGT_CRAM;
      end else if (address < 16'hFE00) begin
         dec.region = RGN_WORK;
      end else if (sprite_hit) begin
         dec.region = RGN_SPRITE;
      end else if (address < 16'hFF00) begin
         dec.region = RGN_NONE;
         dec.target = TGT_NONE;
      end else if (address < 16'hFF80) begin
         dec.region = RGN_IO;
         if (r == IO_JOY) begin
            dec.target = TGT_JOY;
         end else if (is_palette(r) && colour_mode) begin
            dec.target = TGT_PAL;
         end else if (is_sound(r)) begin
            dec.target = TGT_SOUND;
         end
      end else if (address < 16'hFFFF) begin
         dec.region = RGN_HIGH;
      end else begin
         dec.region = RGN_IE;
      end
   end
endmodule

>>> sv/banked_memory_map_decoder.sv
// Top level: banked memory map decoder with sprite-memory DMA
//
//   channel  | dir | words
//   req_bus  | in  | mode, address, write_data, external_data
//   rsp_bus  | out | read_data, target, external_address, external_write, dma_busy
//   csr_bus  | in  | colour_mode
//
// Writes, idle DMA ticks and unused modes register the result as they leave the issue
// state and return to idle; reads and copying DMA ticks go on to a write-back state and
// register it there, from the registered read of the stores.
// After reset the stores are cleared to their reset contents; no request word is taken meanwhile.
// One item is in work at a time; a held result stalls the next item before its store access.
`timescale 1ns / 1ps
module banked_memory_map_decoder #(
   parameter int SPRITE_BYTES = bmmd_pkg::SPRITE_BYTES_DEF,
   parameter int WORK_BANKS   = bmmd_pkg::WORK_BANKS_DEF
) (
   input logic       clock,
   input logic       reset,
   bmmd_req_if.sink  req_bus,
   bmmd_rsp_if.source rsp_bus,
   bmmd_csr_if.sink  csr_bus
);
   import bmmd_pkg::*;

   localparam int WORK_DEPTH = WORK_BANKS * BANK_BYTES;
   localparam int CLR_LEN    = (WORK_DEPTH > VIDEO_DEPTH) ? WORK_DEPTH : VIDEO_DEPTH;
   localparam int CW         = $clog2(CLR_LEN) + 1;
   localparam int WAW        = $clog2(WORK_DEPTH);
   localparam int SAW        = (SPRITE_BYTES > 1) ? $clog2(SPRITE_BYTES) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ISSUE = 4'b0100,
      ST_WB    = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]  mode_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  ext_ff;
   logic        colour_ff;
   logic        vbank_ff, vbank_in;
   logic [2:0]  wbank_ff, wbank_in;
   logic [7:0]  ie_ff, ie_in;
   logic        dma_act_ff, dma_act_in;
   logic [7:0]  dma_hi_ff, dma_hi_in;
   logic [7:0]  dma_idx_ff, dma_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rd_ff, rd_in;
   logic [2:0]  tgt_ff, tgt_in;
   logic [15:0] xaddr_ff, xaddr_in;
   logic        xw_ff, xw_in;
   logic        busy_ff, busy_in;

   logic        clearing, accept, rsp_free, fire, wb, is_ext;
   logic [15:0] src;
   logic [15:0] dec_addr;
   logic [8:0]  dma_next;
   dec_type     dec;
   logic [7:0]  rd_mux;

   logic        vram_we, wram_we, sram_we, hram_we, iram_we;
   logic [13:0] vram_addr;
   logic [WAW-1:0] wram_addr;
   logic [SAW-1:0] sram_addr;
   logic [6:0]  hram_addr, iram_addr;
   logic [7:0]  vram_wd, wram_wd, sram_wd, hram_wd, iram_wd;
   logic [7:0]  vram_rd, wram_rd, sram_rd, hram_rd, iram_rd;

   assign clearing = (state_ff == ST_CLEAR);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire = (state_ff == ST_ISSUE) && rsp_free;
   assign wb = (state_ff == ST_WB);
   assign src = {dma_hi_ff, dma_idx_ff};
   assign dec_addr = (mode_ff == MODE_DMA) ? src : addr_ff;
   assign dma_next = {1'b0, dma_idx_ff} + 9'd1;
   assign is_ext = (dec.target != TGT_INT) && (dec.target != TGT_NONE);

   bmmd_decode #(
      .SPRITE_BYTES(SPRITE_BYTES),
      .WORK_BANKS  (WORK_BANKS)
   ) u_decode (
      .address    (dec_addr),
      .colour_mode(colour_ff),
      .video_bank (vbank_ff),
      .work_bank  (wbank_ff),
      .dec        (dec)
   );

   always_comb begin
      unique case (dec.region)
         RGN_ROM, RGN_CRAM: rd_mux = ext_ff;
         RGN_VIDEO:         rd_mux = vram_rd;
         RGN_WORK:          rd_mux = wram_rd;
         RGN_SPRITE:        rd_mux = sram_rd;
         RGN_NONE:          rd_mux = 8'hFF;
         RGN_IO:            rd_mux = is_ext ? ext_ff : iram_rd;
         RGN_HIGH:          rd_mux = hram_rd;
         RGN_IE:            rd_mux = ie_ff;
         default:           rd_mux = 8'h00;
      endcase
   end

   always_comb begin
      logic wr;
      wr = fire && (mode_ff == MODE_WRITE);

      vram_addr = clearing ? clr_cnt_ff[13:0] : dec.video_addr;
      vram_wd   = clearing ? 8'h00 : wdata_ff;
      vram_we   = (clearing && clr_cnt_ff < CW'(VIDEO_DEPTH)) || (wr && dec.region == RGN_VIDEO);

      wram_addr = clearing ? clr_cnt_ff[WAW-1:0] : dec.work_addr[WAW-1:0];
      wram_wd   = clearing ? 8'h00 : wdata_ff;
      wram_we   = (clearing && clr_cnt_ff < CW'(WORK_DEPTH)) || (wr && dec.region == RGN_WORK);

      if (clearing) begin
         sram_addr = clr_cnt_ff[SAW-1:0];
         sram_wd   = 8'h00;
      end else if (wb && mode_ff == MODE_DMA) begin
         sram_addr = dma_idx_ff[SAW-1:0];
         sram_wd   = rd_mux;
      end else begin
         sram_addr = dec.sprite_addr[SAW-1:0];
         sram_wd   = wdata_ff;
      end
      sram_we = (clearing && clr_cnt_ff < CW'(SPRITE_BYTES))
             || (wr && dec.region == RGN_SPRITE)
             || (wb && mode_ff == MODE_DMA);

      hram_addr = clearing ? clr_cnt_ff[6:0] : dec.low_addr;
      hram_wd   = clearing ? 8'h00 : wdata_ff;
      hram_we   = (clearing && clr_cnt_ff < CW'(HIGH_DEPTH)) || (wr && dec.region == RGN_HIGH);

      iram_addr = clearing ? clr_cnt_ff[6:0] : dec.low_addr;
      if (clearing) begin
         iram_wd = boot_io(clr_cnt_ff[6:0]);
      end else begin
         iram_wd = (dec.low_addr == IO_DIV) ? 8'h00 : wdata_ff;
      end
      iram_we = (clearing && clr_cnt_ff < CW'(IO_DEPTH)) || (wr && dec.region == RGN_IO);
   end

   bmmd_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video_ram (
      .clock(clock), .we(vram_we), .addr(vram_addr), .wdata(vram_wd), .rdata(vram_rd)
   );
   bmmd_ram #(.WIDTH(8), .DEPTH(WORK_DEPTH)) u_work_ram (
      .clock(clock), .we(wram_we), .addr(wram_addr), .wdata(wram_wd), .rdata(wram_rd)
   );
   bmmd_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite_ram (
      .clock(clock), .we(sram_we), .addr(sram_addr), .wdata(sram_wd), .rdata(sram_rd)
   );
   bmmd_ram #(.WIDTH(8), .DEPTH(HIGH_DEPTH)) u_high_ram (
      .clock(clock), .we(hram_we), .addr(hram_addr), .wdata(hram_wd), .rdata(hram_rd)
   );
   bmmd_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io_ram (
      .clock(clock), .we(iram_we), .addr(iram_addr), .wdata(iram_wd), .rdata(iram_rd)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      vbank_in     = vbank_ff;
      wbank_in     = wbank_ff;
      ie_in        = ie_ff;
      dma_act_in   = dma_act_ff;
      dma_hi_in    = dma_hi_ff;
      dma_idx_in   = dma_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_in        = rd_ff;
      tgt_in       = tgt_ff;
      xaddr_in     = xaddr_ff;
      xw_in        = xw_ff;
      busy_in      = busy_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CW'(CLR_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (fire) begin
               if (mode_ff == MODE_READ || (mode_ff == MODE_DMA && dma_act_ff)) begin
                  state_in = ST_WB;
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rd_in        = 8'h00;
                  tgt_in       = TGT_INT;
                  xaddr_in     = 16'h0000;
                  xw_in        = 1'b0;
                  busy_in      = dma_act_ff;
                  if (mode_ff == MODE_WRITE) begin
                     tgt_in   = dec.target;
                     xaddr_in = is_ext ? addr_ff : 16'h0000;
                     xw_in    = is_ext;
                     if (dec.region == RGN_IE) begin
                        ie_in = wdata_ff;
                     end
                     if (dec.region == RGN_IO) begin
                        if (dec.low_addr == IO_DMA) begin
                           dma_act_in = 1'b1;
                           dma_hi_in  = wdata_ff;
                           dma_idx_in = 8'h00;
                           busy_in    = 1'b1;
                        end else if (dec.low_addr == IO_VBK && colour_ff) begin
                           vbank_in = wdata_ff[0];
                        end else if (dec.low_addr == IO_SVBK && colour_ff) begin
                           wbank_in = (wdata_ff[2:0] == 3'd0) ? 3'd1 : wdata_ff[2:0];
                        end
                     end
                  end
               end
            end
         end
         ST_WB: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rd_in        = rd_mux;
            tgt_in       = dec.target;
            xw_in        = 1'b0;
            if (mode_ff == MODE_DMA) begin
               xaddr_in   = src;
               dma_idx_in = dma_next[7:0];
               dma_act_in = dma_next < 9'(SPRITE_BYTES);
               busy_in    = dma_next < 9'(SPRITE_BYTES);
            end else begin
               xaddr_in = is_ext ? addr_ff : 16'h0000;
               busy_in  = dma_act_ff;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         colour_ff    <= 1'b0;
         vbank_ff     <= 1'b0;
         wbank_ff     <= 3'd1;
         ie_ff        <= 8'h00;
         dma_act_ff   <= 1'b0;
         dma_hi_ff    <= 8'h00;
         dma_idx_ff   <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         vbank_ff     <= vbank_in;
         wbank_ff     <= wbank_in;
         ie_ff        <= ie_in;
         dma_act_ff   <= dma_act_in;
         dma_hi_ff    <= dma_hi_in;
         dma_idx_ff   <= dma_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            colour_ff <= csr_bus.colour_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_bus.mode;
         addr_ff  <= req_bus.address;
         wdata_ff <= req_bus.write_data;
         ext_ff   <= req_bus.external_data;
      end
      rd_ff    <= rd_in;
      tgt_ff   <= tgt_in;
      xaddr_ff <= xaddr_in;
      xw_ff    <= xw_in;
      busy_ff  <= busy_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.read_data        = rd_ff;
   assign rsp_bus.target           = tgt_ff;
   assign rsp_bus.external_address = xaddr_ff;
   assign rsp_bus.external_write   = xw_ff;
   assign rsp_bus.dma_busy         = busy_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_bus.ready)
      else $error("request taken during store clear");

   a_wb_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB |-> !rsp_valid_ff)
      else $error("read completion with response slot occupied");

   a_dma_index_range: assert property (@(posedge clock) disable iff (reset)
      dma_act_ff |-> ({1'b0, dma_idx_ff} < 9'(SPRITE_BYTES)))
      else $error("DMA index beyond sprite memory");

   a_issue_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ISSUE)
      else $error("accepted word not issued");
endmodule

>>> sim/banked_memory_map_decoder_test.sv
// Testbench for the banked memory map decoder: predicted bus accesses and DMA ticks vs RTL
`timescale 1ns / 1ps
module banked_memory_map_decoder_test;
   import bmmd_pkg::*;

   localparam int SPRITES = SPRITE_BYTES_DEF;
   localparam int BANKS   = WORK_BANKS_DEF;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  target;
      logic [15:0] external_address;
      logic        external_write;
      logic        dma_busy;
   } word_type;

   logic clock = 0;
   logic reset = 1;

   bmmd_req_if req_bus();
   bmmd_rsp_if rsp_bus();
   bmmd_csr_if csr_bus();

   banked_memory_map_decoder dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic [7:0] video_mem [VIDEO_DEPTH];
   logic [7:0] work_mem [BANKS * BANK_BYTES];
   logic [7:0] sprite_mem [256];
   logic [7:0] high_mem [HIGH_DEPTH];
   logic [7:0] io_mem [IO_DEPTH];
   logic [7:0] ie_reg;
   logic       vbank;
   logic [2:0] wbank;
   logic       dma_on;
   logic [15:0] dma_src;
   logic [7:0] dma_pos;
   logic       colour;

   word_type expected_words[$];
   int mismatches = 0;
   int words_seen = 0;
   int items_sent = 0;
   int dma_copies = 0;

   function automatic int video_index(logic [15:0] a);
      return colour ? int'(vbank) * 'h2000 + int'(a[12:0]) : int'(a[12:0]);
   endfunction

   function automatic int work_index(logic [15:0] a);
      int bank;
      if (a < 16'hD000) return int'(a[11:0]);
      bank = colour ? int'(wbank) : 1;
      if (bank >= BANKS) bank = BANKS - 1;
      return bank * BANK_BYTES + int'(a[11:0]);
   endfunction

   function automatic logic sound_reg(logic [6:0] r);
      return (r >= 7'h10 && r <= 7'h26) || (r >= 7'h30 && r <= 7'h3F);
   endfunction

   function automatic logic palette_reg(logic [6:0] r);
      return r >= 7'h68 && r <= 7'h6B;
   endfunction

   function automatic logic [7:0] bus_fetch(logic [15:0] a, logic [7:0] ext,
                                             output logic [2:0] tgt);
      logic [6:0] r;
      r = a[6:0];
      tgt = TGT_INT;
      if (a < 16'h8000) begin tgt = TGT_ROM; return ext; end
      if (a < 16'hA000) return video_mem[video_index(a)];
      if (a < 16'hC000) begin tgt = TGT_CRAM; return ext; end
      if (a < 16'hFE00) begin
         if (a >= 16'hE000) a = a - 16'h2000;
         return work_mem[work_index(a)];
      end
      if (a < 16'hFE00 + SPRITES) return sprite_mem[(a - 16'hFE00) & 16'hFF];
      if (a < 16'hFF00) begin tgt = TGT_NONE; return 8'hFF; end
      if (a < 16'hFF80) begin
         if (r == IO_JOY) begin tgt = TGT_JOY; return ext; end
         if (palette_reg(r) && colour) begin tgt = TGT_PAL; return ext; end
         if (sound_reg(r)) begin tgt = TGT_SOUND; return ext; end
         return io_mem[r];
      end
      if (a < 16'hFFFF) return high_mem[a - 16'hFF80];
      return ie_reg;
   endfunction

   function automatic void bus_store(logic [15:0] a, logic [7:0] v,
                                     output logic [2:0] tgt, output logic xw);
      logic [6:0] r;
      r = a[6:0];
      tgt = TGT_INT;
      xw = 0;
      if (a < 16'h8000) begin tgt = TGT_ROM; xw = 1; end
      else if (a < 16'hA000) video_mem[video_index(a)] = v;
      else if (a < 16'hC000) begin tgt = TGT_CRAM; xw = 1; end
      else if (a < 16'hFE00) begin
         if (a >= 16'hE000) a = a - 16'h2000;
         work_mem[work_index(a)] = v;
      end else if (a < 16'hFE00 + SPRITES) sprite_mem[(a - 16'hFE00) & 16'hFF] = v;
      else if (a < 16'hFF00) tgt = TGT_NONE;
      else if (a < 16'hFF80) begin
         if (r == IO_DMA) begin
            dma_on = 1;
            dma_src = {v, 8'h00};
            dma_pos = 0;
         end else if (r == IO_VBK) begin
            if (colour) vbank = v[0];
         end else if (r == IO_SVBK) begin
            if (colour) wbank = (v[2:0] == 0) ? 3'd1 : v[2:0];
         end else if (r == IO_JOY) begin
            tgt = TGT_JOY; xw = 1;
         end else if (palette_reg(r)) begin
            if (colour) begin tgt = TGT_PAL; xw = 1; end
         end else if (sound_reg(r)) begin
            tgt = TGT_SOUND; xw = 1;
         end
         io_mem[r] = (r == IO_DIV) ? 8'h00 : v;
      end else if (a < 16'hFFFF) high_mem[a - 16'hFF80] = v;
      else ie_reg = v;
   endfunction

   function automatic word_type decode_access(logic [1:0] mode, logic [15:0] a,
                                              logic [7:0] wd, logic [7:0] ext);
      word_type w;
      logic [2:0] tgt;
      logic xw;
      w = '0;
      if (mode == MODE_READ) begin
         w.read_data = bus_fetch(a, ext, tgt);
         w.target = tgt;
         if (tgt != TGT_INT && tgt != TGT_NONE) w.external_address = a;
      end else if (mode == MODE_WRITE) begin
         bus_store(a, wd, tgt, xw);
         w.target = tgt;
         w.external_write = xw;
         if (tgt != TGT_INT && tgt != TGT_NONE) w.external_address = a;
      end else if (mode == MODE_DMA && dma_on) begin
         if (dma_pos < SPRITES) begin
            w.external_address = dma_src + dma_pos;
            w.read_data = bus_fetch(w.external_address, ext, tgt);
            w.target = tgt;
            sprite_mem[dma_pos] = w.read_data;
            dma_copies++;
         end
         if (int'(dma_pos) + 1 >= SPRITES) dma_on = 0;
         dma_pos = dma_pos + 1;
      end
      w.dma_busy = dma_on;
      return w;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (n != 0) begin
         req_bus.valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_access(logic [1:0] mode, logic [15:0] a, logic [7:0] wd,
                              logic [7:0] ext);
      req_bus.valid <= 1;
      req_bus.mode <= mode;
      req_bus.address <= a;
      req_bus.write_data <= wd;
      req_bus.external_data <= ext;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_words.push_back(decode_access(mode, a, wd, ext));
      items_sent++;
      @(negedge clock);
      idle_gap();
   endtask

   task automatic write_colour(logic v);
      req_bus.valid <= 0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_bus.valid <= 1;
      csr_bus.colour_mode <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      colour = v;
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   always @(posedge clock) begin
      word_type w, e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         w = {rsp_bus.read_data, rsp_bus.target, rsp_bus.external_address,
              rsp_bus.external_write, rsp_bus.dma_busy};
         words_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", w);
         end else begin
            e = expected_words.pop_front();
            if (w !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected rd %h tgt %0d xa %h xw %b busy %b, got rd %h tgt %0d xa %h xw %b busy %b",
                           e.read_data, e.target, e.external_address, e.external_write,
                           e.dma_busy, w.read_data, w.target, w.external_address,
                           w.external_write, w.dma_busy);
            end
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 9) < 7) rsp_bus.ready <= 1;
      else rsp_bus.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : $urandom_range(0, 1);
   end

   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 11))
         0: return $urandom_range(0, 16'h7FFF);
         1, 2: return $urandom_range(16'h8000, 16'h9FFF);
         3: return $urandom_range(16'hA000, 16'hBFFF);
         4, 5: return $urandom_range(16'hC000, 16'hDFFF);
         6: return $urandom_range(16'hE000, 16'hFDFF);
         7: return $urandom_range(16'hFE00, 16'hFEFF);
         8, 9: return $urandom_range(16'hFF00, 16'hFF7F);
         10: return $urandom_range(16'hFF80, 16'hFFFF);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic test_directed();
      send_access(MODE_READ, 16'hFF00, 8'h00, 8'hA5);
      send_access(MODE_READ, 16'hFF04, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'hFF04, 8'hFF, 8'h00);
      send_access(MODE_READ, 16'hFF04, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'h0000, 8'hFF, 8'h00);
      send_access(MODE_WRITE, 16'hFFFF, 8'hFF, 8'hFF);
      send_access(MODE_READ, 16'hFFFF, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'hC123, 8'h5A, 8'h00);
      send_access(MODE_READ, 16'hE123, 8'h00, 8'h00);
      send_access(MODE_READ, 16'hFEA0, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'hFEFF, 8'h11, 8'h00);
      send_access(MODE_WRITE, 16'hFF68, 8'h22, 8'h00);
      send_access(MODE_READ, 16'hFF26, 8'h00, 8'hC3);
      send_access(MODE_DMA, 16'h0000, 8'h00, 8'h00);
      send_access(2'd3, 16'hFFFF, 8'hFF, 8'hFF);
      send_access(MODE_WRITE, 16'hFF46, 8'hC1, 8'h00);
      send_access(MODE_DMA, 16'h0000, 8'h00, 8'h00);
      send_access(MODE_DMA, 16'h0000, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'hFF46, 8'hFF, 8'h00);
      repeat (SPRITES) send_access(MODE_DMA, 16'h0000, 8'h00, $urandom_range(0, 255));
      send_access(MODE_READ, 16'hFE9F, 8'h00, 8'h00);
   endtask

   task automatic test_banking();
      write_colour(1);
      send_access(MODE_WRITE, 16'hFF70, 8'h00, 8'h00);
      send_access(MODE_WRITE, 16'hD000, 8'h77, 8'h00);
      send_access(MODE_WRITE, 16'hFF70, 8'hFF, 8'h00);
      send_access(MODE_WRITE, 16'hDFFF, 8'h88, 8'h00);
      send_access(MODE_WRITE, 16'hFF4F, 8'h01, 8'h00);
      send_access(MODE_WRITE, 16'h9FFF, 8'h99, 8'h00);
      send_access(MODE_READ, 16'hFF6B, 8'h00, 8'h3C);
      send_access(MODE_WRITE, 16'hFF6A, 8'h44, 8'h00);
   endtask

   task automatic test_random(int count);
      logic [1:0] m;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 19);
         m = (k < 9) ? MODE_READ : (k < 16) ? MODE_WRITE : (k < 19) ? MODE_DMA : 2'd3;
         if (k == 15)
            send_access(MODE_WRITE, {9'h1FE, 7'($urandom_range(0, 1) ? IO_DMA :
                        ($urandom_range(0, 1) ? IO_VBK : IO_SVBK))},
                        $urandom_range(0, 255), 0);
         else
            send_access(m, pick_address(), $urandom_range(0, 255), $urandom_range(0, 255));
         if (i % 150 == 149) write_colour($urandom_range(0, 1));
      end
   endtask

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.mode = 0;
      req_bus.address = 0;
      req_bus.write_data = 0;
      req_bus.external_data = 0;
      rsp_bus.ready = 1;
      csr_bus.valid = 0;
      csr_bus.colour_mode = 0;
      foreach (video_mem[i]) video_mem[i] = 0;
      foreach (work_mem[i]) work_mem[i] = 0;
      foreach (sprite_mem[i]) sprite_mem[i] = 0;
      foreach (high_mem[i]) high_mem[i] = 0;
      foreach (io_mem[i]) io_mem[i] = boot_io(7'(i));
      ie_reg = 0; vbank = 0; wbank = 1; dma_on = 0; dma_src = 0; dma_pos = 0;
      colour = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_colour(0);
      test_directed();
      test_banking();
      write_colour(0);
      test_random(230);
      write_colour(1);
      test_random(230);
      write_colour(0);
      while (expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d accesses and ticks, checked %0d words, %0d DMA copies",
               items_sent, words_seen, dma_copies);
      if (mismatches == 0 && expected_words.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
